// ----- rtl/core/lfid_pkg.sv -----
// shared types and constants for the lowest free id allocator
// no dependencies; imported by lfid_ram users and the core top level
`default_nettype none

package lfid_pkg;

    localparam int ID_W          = 24;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int POOL_SIZE_DEF = 65536;

    localparam logic [ID_W-1:0] BASE_ID_RESET  = 24'd4096;
    localparam logic [ID_W-1:0] LIMIT_ID_RESET = 24'd16777214;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ID = 1'b1;

    typedef enum logic {
        OP_ALLOC,
        OP_RELEASE
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_EXHAUSTED,
        STATUS_NOT_ALLOC
    } status_t;

    typedef struct packed {
        op_t              operation;
        logic [ID_W-1:0]  release_id;
    } in_beat_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  result_id;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP_A,
        ST_PREP_B,
        ST_PREP_C,
        ST_SCAN,
        ST_GRANT,
        ST_REL_RD,
        ST_REL_CHK,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lfid_ram.sv -----
// generic single-clock ram, one write port and one read port
// read data registered; no dependencies
`default_nettype none

module lfid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/lowest_free_id_allocator_core.sv -----
// lowest free id allocator: next-fit search over a used-id bitmap held in ram
// allocate: PREP_A/B/C, SCAN reads 64-bit bitmap words one per cycle, GRANT sets the bit;
// exhausted when the scan finds nothing free or the pointer is already above the ceiling
// release: PREP_A/B, REL_RD, REL_CHK, straight to the result outside the window; one item
// in flight, next beat accepted once the result is registered; reset and every base_id
// write clear all MAP_WORDS words (1024 by default), no beat accepted; uses lfid_pkg, lfid_ram
`default_nettype none

module lowest_free_id_allocator_core #(
    parameter int POOL_SIZE = lfid_pkg::POOL_SIZE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire lfid_pkg::in_beat_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output lfid_pkg::out_beat_t                m_data,
    input  wire logic                          cfg_we,
    input  wire logic [lfid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lfid_pkg::ID_W-1:0]      cfg_wdata
);

    import lfid_pkg::*;

    localparam int MAP_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W     = $clog2(POOL_SIZE);

    localparam logic [ID_W:0]     POOL_LEN  = (ID_W + 1)'(POOL_SIZE);
    localparam logic [ID_W:0]     POOL_SPAN = (ID_W + 1)'(POOL_SIZE - 1);
    localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [ID_W-1:0]   ID_MAX    = '1;
    localparam logic [ID_W:0]     ONE_WIDE  = (ID_W + 1)'(1);
    localparam logic [WORD_W-1:0] WORD_ONE  = WORD_W'(1);
    localparam logic [WORD_W-1:0] WORD_TWO  = WORD_W'(2);

    // control state
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [ID_W-1:0]   base_reg, base_next;
    logic [ID_W-1:0]   limit_reg, limit_next;
    logic [ID_W-1:0]   nc_reg, nc_next;
    logic              m_valid_reg, m_valid_next;
    logic              pend_reg, pend_next;

    // per-item working registers
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [ID_W-1:0]   start_reg, start_next;
    logic [ID_W-1:0]   wintop_reg, wintop_next;
    logic [ID_W-1:0]   top_reg, top_next;
    logic [ID_W:0]     rel_diff_reg, rel_diff_next;
    logic [AW-1:0]     first_w_reg, first_w_next;
    logic [AW-1:0]     last_w_reg, last_w_next;
    logic [AW-1:0]     scan_w_reg, scan_w_next;
    logic [AW-1:0]     eval_w_reg, eval_w_next;
    logic [WORD_W-1:0] lo_mask_reg, lo_mask_next;
    logic [WORD_W-1:0] hi_mask_reg, hi_mask_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [BIT_W-1:0]  bit_idx_reg, bit_idx_next;
    status_t           res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    out_beat_t         m_data_reg, m_data_next;

    // bitmap ram
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // datapath helpers
    logic [ID_W:0]     win_sum;
    logic [OFF_W-1:0]  rel_off;
    logic [OFF_W-1:0]  start_off;
    logic [OFF_W-1:0]  top_off;
    logic [WORD_W-1:0] masked_word;
    logic              zero_found;
    logic [BIT_W-1:0]  zero_idx;
    logic [ID_W-1:0]   grant_off;
    logic [ID_W:0]     grant_sum;
    logic [ID_W:0]     nc_sum;

    lfid_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign win_sum   = {1'b0, base_reg} + POOL_SPAN;
    assign rel_off   = OFF_W'(rel_diff_reg[ID_W-1:0]);
    assign start_off = OFF_W'(start_reg - base_reg);
    assign top_off   = OFF_W'(top_reg - base_reg);
    assign grant_off = ID_W'({eval_w_reg, bit_idx_reg});
    assign grant_sum = {1'b0, base_reg} + {1'b0, grant_off};
    assign nc_sum    = {1'b0, base_reg} + {1'b0, grant_off} + ONE_WIDE;

    // bits outside the search range read as used
    assign masked_word = ram_rdata
                       | ((eval_w_reg == first_w_reg) ? lo_mask_reg : '0)
                       | ((eval_w_reg == last_w_reg) ? hi_mask_reg : '0);

    // lowest clear bit
    always_comb begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!masked_word[i]) begin
                zero_found = 1'b1;
                zero_idx   = BIT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            base_reg     <= BASE_ID_RESET;
            limit_reg    <= LIMIT_ID_RESET;
            nc_reg       <= BASE_ID_RESET;
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            base_reg     <= base_next;
            limit_reg    <= limit_next;
            nc_reg       <= nc_next;
            m_valid_reg  <= m_valid_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        rid_reg        <= rid_next;
        start_reg      <= start_next;
        wintop_reg     <= wintop_next;
        top_reg        <= top_next;
        rel_diff_reg   <= rel_diff_next;
        first_w_reg    <= first_w_next;
        last_w_reg     <= last_w_next;
        scan_w_reg     <= scan_w_next;
        eval_w_reg     <= eval_w_next;
        lo_mask_reg    <= lo_mask_next;
        hi_mask_reg    <= hi_mask_next;
        word_reg       <= word_next;
        bit_idx_reg    <= bit_idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        base_next       = base_reg;
        limit_next      = limit_reg;
        nc_next         = nc_reg;
        m_valid_next    = m_valid_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        rid_next        = rid_reg;
        start_next      = start_reg;
        wintop_next     = wintop_reg;
        top_next        = top_reg;
        rel_diff_next   = rel_diff_reg;
        first_w_next    = first_w_reg;
        last_w_next     = last_w_reg;
        scan_w_next     = scan_w_reg;
        eval_w_next     = eval_w_reg;
        lo_mask_next    = lo_mask_reg;
        hi_mask_next    = hi_mask_reg;
        word_next       = word_reg;
        bit_idx_next    = bit_idx_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        m_data_next     = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        ram_raddr = scan_w_reg;
        s_ready   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_data.operation;
                    rid_next   = s_data.release_id;
                    state_next = ST_PREP_A;
                end
            end
            ST_PREP_A: begin
                start_next    = (nc_reg < base_reg) ? base_reg : nc_reg;
                wintop_next   = win_sum[ID_W] ? ID_MAX : win_sum[ID_W-1:0];
                rel_diff_next = {1'b0, rid_reg} - {1'b0, base_reg};
                state_next    = ST_PREP_B;
            end
            ST_PREP_B: begin
                case (op_reg)
                    OP_ALLOC: begin
                        top_next   = (limit_reg < wintop_reg) ? limit_reg : wintop_reg;
                        state_next = ST_PREP_C;
                    end
                    OP_RELEASE: begin
                        if (!rel_diff_reg[ID_W]
                                && ({1'b0, rel_diff_reg[ID_W-1:0]} < POOL_LEN)) begin
                            scan_w_next  = AW'(rel_off >> BIT_W);
                            bit_idx_next = rel_off[BIT_W-1:0];
                            state_next   = ST_REL_RD;
                        end else begin
                            res_status_next = STATUS_NOT_ALLOC;
                            res_id_next     = rid_reg;
                            state_next      = ST_RESP;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_PREP_C: begin
                if (start_reg > top_reg) begin
                    res_status_next = STATUS_EXHAUSTED;
                    res_id_next     = '0;
                    state_next      = ST_RESP;
                end else begin
                    first_w_next = AW'(start_off >> BIT_W);
                    last_w_next  = AW'(top_off >> BIT_W);
                    scan_w_next  = AW'(start_off >> BIT_W);
                    lo_mask_next = (WORD_ONE << start_off[BIT_W-1:0]) - WORD_ONE;
                    hi_mask_next = ~((WORD_TWO << top_off[BIT_W-1:0]) - WORD_ONE);
                    pend_next    = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_raddr   = scan_w_reg;
                eval_w_next = scan_w_reg;
                pend_next   = 1'b1;
                if (scan_w_reg != last_w_reg) begin
                    scan_w_next = scan_w_reg + AW'(1);
                end
                if (pend_reg) begin
                    if (zero_found) begin
                        word_next    = ram_rdata;
                        bit_idx_next = zero_idx;
                        eval_w_next  = eval_w_reg;
                        state_next   = ST_GRANT;
                    end else if (eval_w_reg == last_w_reg) begin
                        nc_next         = (top_reg == ID_MAX) ? ID_MAX : top_reg + ID_W'(1);
                        res_status_next = STATUS_EXHAUSTED;
                        res_id_next     = '0;
                        state_next      = ST_RESP;
                    end
                end
            end
            ST_GRANT: begin
                ram_we          = 1'b1;
                ram_waddr       = eval_w_reg;
                ram_wdata       = word_reg | (WORD_ONE << bit_idx_reg);
                nc_next         = nc_sum[ID_W] ? ID_MAX : nc_sum[ID_W-1:0];
                res_status_next = STATUS_OK;
                res_id_next     = grant_sum[ID_W-1:0];
                state_next      = ST_RESP;
            end
            ST_REL_RD: begin
                ram_raddr  = scan_w_reg;
                state_next = ST_REL_CHK;
            end
            ST_REL_CHK: begin
                res_id_next = rid_reg;
                if (ram_rdata[bit_idx_reg]) begin
                    ram_we          = 1'b1;
                    ram_waddr       = scan_w_reg;
                    ram_wdata       = ram_rdata & ~(WORD_ONE << bit_idx_reg);
                    res_status_next = STATUS_OK;
                    if (rid_reg < nc_reg) begin
                        nc_next = rid_reg;
                    end
                end else begin
                    res_status_next = STATUS_NOT_ALLOC;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = res_status_reg;
                    m_data_next.result_id = res_id_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new base moves the window: reload the pointer and clear the bitmap
        if (cfg_we) begin
            if (cfg_index == REG_BASE_ID) begin
                base_next     = cfg_wdata;
                nc_next       = cfg_wdata;
                clr_addr_next = '0;
                state_next    = ST_CLEAR;
            end else if (cfg_index == REG_LIMIT_ID) begin
                limit_next = cfg_wdata;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- dv/lowest_free_id_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// testbench for lowest_free_id_allocator_core: directed and random allocate/release beats,
// predicted by a bitmap model of the id pool inside a small scoreboard class
// depends on lfid_pkg and the core rtl with its ram

module lowest_free_id_allocator_core_tb;
    import lfid_pkg::*;

    localparam int     POOL            = POOL_SIZE_DEF;
    localparam int     MAP_WORDS       = (POOL + 63) / 64;
    localparam longint ID_MAX          = 64'hFF_FFFF;
    localparam int     LONG_HOLD       = 400;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     ITEMS_PER_PHASE = 72;
    localparam int     END_DRAIN       = 1100;
    localparam int     MAX_ERR_LINES   = 40;
    localparam longint TIMEOUT_NS      = 40_000_000;

    class id_pool_scoreboard;
        bit [63:0]     used_words [MAP_WORDS];
        bit [ID_W-1:0] base_reg;
        bit [ID_W-1:0] limit_reg;
        bit [ID_W-1:0] next_ptr;
        bit [ID_W-1:0] live_ids [$];
        out_beat_t     expected_q [$];
        int            errors;
        int            checked;

        function new();
            base_reg  = BASE_ID_RESET;
            limit_reg = LIMIT_ID_RESET;
            clear_pool();
        endfunction

        function void clear_pool();
            foreach (used_words[i]) used_words[i] = '0;
            live_ids.delete();
            next_ptr = base_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
            case (idx)
                REG_BASE_ID: begin
                    base_reg = val;
                    clear_pool();
                end
                REG_LIMIT_ID: begin
                    limit_reg = val;
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int live_count();
            return live_ids.size();
        endfunction

        function bit [ID_W-1:0] pick_live_id();
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        endfunction

        function out_beat_t grant_next();
            longint    top;
            longint    start;
            longint    cand;
            longint    off;
            out_beat_t res;
            top = limit_reg;
            if (longint'(base_reg) + POOL - 1 < top) top = longint'(base_reg) + POOL - 1;
            if (top > ID_MAX) top = ID_MAX;
            start = (next_ptr < base_reg) ? longint'(base_reg) : longint'(next_ptr);
            cand = start;
            while (cand <= top) begin
                off = cand - longint'(base_reg);
                if (off >= POOL) break;
                if (!used_words[off >> 6][off[5:0]]) break;
                if (off[5:0] == 6'd0 && &used_words[off >> 6]) cand += 64;
                else cand += 1;
            end
            if (cand > top || cand < longint'(base_reg) || cand - longint'(base_reg) >= POOL)
            begin
                if (start <= top) next_ptr = ID_W'((top + 1 > ID_MAX) ? ID_MAX : top + 1);
                res.status    = STATUS_EXHAUSTED;
                res.result_id = '0;
            end else begin
                off = cand - longint'(base_reg);
                used_words[off >> 6][off[5:0]] = 1'b1;
                next_ptr = ID_W'((cand + 1 > ID_MAX) ? ID_MAX : cand + 1);
                live_ids.push_back(ID_W'(cand));
                res.status    = STATUS_OK;
                res.result_id = ID_W'(cand);
            end
            return res;
        endfunction

        function out_beat_t free_id(bit [ID_W-1:0] rid);
            longint    off;
            out_beat_t res;
            res.status    = STATUS_NOT_ALLOC;
            res.result_id = rid;
            if (rid >= base_reg && longint'(rid) - longint'(base_reg) < POOL) begin
                off = longint'(rid) - longint'(base_reg);
                if (used_words[off >> 6][off[5:0]]) begin
                    used_words[off >> 6][off[5:0]] = 1'b0;
                    if (rid < next_ptr) next_ptr = rid;
                    res.status = STATUS_OK;
                    for (int i = 0; i < live_ids.size(); i++) begin
                        if (live_ids[i] == rid) begin
                            live_ids.delete(i);
                            break;
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_input(in_beat_t beat);
            if (beat.operation == OP_ALLOC) expected_q.push_back(grant_next());
            else expected_q.push_back(free_id(beat.release_id));
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_ERR_LINES) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(out_beat_t got);
            out_beat_t exp;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status %0d id 0x%06h",
                                          got.status, got.result_id));
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status)
                report_mismatch($sformatf("status got %0d want %0d (want id 0x%06h)",
                                          got.status, exp.status, exp.result_id));
            if (got.result_id !== exp.result_id)
                report_mismatch($sformatf("result_id got 0x%06h want 0x%06h",
                                          got.result_id, exp.result_id));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_beat_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_beat_t            m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0]      cfg_wdata;
    bit                   hold_request;
    bit                   long_hold_done;

    id_pool_scoreboard sb = new();

    lowest_free_id_allocator_core #(
        .POOL_SIZE(POOL)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) sb.check_result(m_data);
    end

    initial begin : result_sink
        int r;
        int run;
        bit level;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_request && !long_hold_done) begin
                level = 1'b0;
                run = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (r < 55) begin
                level = 1'b1;
                run = $urandom_range(1, 12);
            end else if (r < 80) begin
                level = 1'b0;
                run = $urandom_range(1, 2);
            end else if (r < 92) begin
                level = 1'b1;
                run = $urandom_range(40, 150);
            end else begin
                level = 1'b0;
                run = $urandom_range(6, 50);
            end
            m_ready <= level;
            repeat (run) @(negedge aclk);
        end
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input in_beat_t beat, input bit steady);
        int gap;
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(beat);
        @(negedge aclk);
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic do_alloc(input bit steady);
        in_beat_t beat;
        beat.operation  = OP_ALLOC;
        beat.release_id = ID_W'($urandom());
        send_beat(beat, steady);
    endtask

    task automatic do_release(input logic [ID_W-1:0] rid, input bit steady);
        in_beat_t beat;
        beat.operation  = OP_RELEASE;
        beat.release_id = rid;
        send_beat(beat, steady);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    function automatic logic [ID_W-1:0] sat_add(input logic [ID_W-1:0] b, input int span);
        longint t;
        t = longint'(b) + span;
        return ID_W'((t > ID_MAX) ? ID_MAX : t);
    endfunction

    task automatic set_phase_config(input int ph);
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] l;
        b = ID_W'($urandom());
        case (ph)
            0: begin
                b = '0;
                l = ID_W'(ID_MAX);
            end
            2: begin
                b = ID_W'(ID_MAX - $urandom_range(20, 120));
                l = ID_W'(ID_MAX);
            end
            3: l = sat_add(b, $urandom_range(60, 300));
            5: begin
                b = ID_W'($urandom_range(1, 32'hFF_FFFF));
                l = ID_W'($urandom_range(0, b - 1));
            end
            7: l = ID_W'(ID_MAX);
            default: l = sat_add(b, $urandom_range(30, 160));
        endcase
        if (ph == 4) begin
            // pull the limit under the pointer without moving the window
            if (sb.next_ptr > sb.base_reg + 8) l = sb.next_ptr - ID_W'($urandom_range(1, 8));
            else l = sb.base_reg;
        end else begin
            write_cfg(REG_BASE_ID, b);
        end
        write_cfg(REG_LIMIT_ID, l);
    endtask

    task automatic random_item(input bit steady);
        int              r;
        logic [ID_W-1:0] rid;
        r = $urandom_range(0, 99);
        if (r < 52) begin
            do_alloc(steady);
        end else if (r < 84 && sb.live_count() > 0) begin
            do_release(sb.pick_live_id(), steady);
        end else begin
            case ($urandom_range(0, 3))
                0: rid = ID_W'($urandom());
                1: rid = sb.base_reg - 1'b1;
                2: rid = sb.base_reg + ID_W'(POOL);
                default: rid = sb.base_reg + ID_W'($urandom_range(0, 200));
            endcase
            do_release(rid, steady);
        end
    endtask

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("** lowest_free_id_allocator_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_BASE_ID;
        cfg_wdata = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // reset window
        do_release(BASE_ID_RESET, 1'b0);
        do_alloc(1'b0);
        do_alloc(1'b0);
        do_alloc(1'b0);
        do_release(BASE_ID_RESET + ID_W'(1), 1'b0);
        do_alloc(1'b0);
        do_release('0, 1'b0);
        do_release(ID_W'(ID_MAX), 1'b0);
        do_release(BASE_ID_RESET + ID_W'(POOL), 1'b0);
        do_release(BASE_ID_RESET, 1'b0);
        do_release(BASE_ID_RESET, 1'b0);
        do_alloc(1'b0);

        // window at the top of the id space, pointer saturates
        drain_results();
        write_cfg(REG_BASE_ID, ID_W'(ID_MAX - 7));
        write_cfg(REG_LIMIT_ID, ID_W'(ID_MAX));
        repeat (9) do_alloc(1'b0);
        do_release(ID_W'(ID_MAX - 3), 1'b0);
        do_alloc(1'b0);

        // zero limit, then limit below base
        drain_results();
        write_cfg(REG_BASE_ID, '0);
        write_cfg(REG_LIMIT_ID, '0);
        do_alloc(1'b0);
        do_alloc(1'b0);
        drain_results();
        write_cfg(REG_BASE_ID, ID_W'(ID_MAX));
        do_alloc(1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            set_phase_config(ph);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 1 && k == 40) drain_results();
                if (ph == 2 && k == 20) hold_request = 1'b1;
                if (ph == 4 && k == 36) begin
                    drain_results();
                    write_cfg(REG_LIMIT_ID, sb.base_reg + ID_W'(400));
                end
                random_item((ph % 3 == 1) && k < 30);
            end
        end

        drain_results();
        repeat (END_DRAIN) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("** lowest_free_id_allocator_core: PASSED **");
        end else begin
            $display("** lowest_free_id_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
